// ===== hw/rtl/lipr_pkg.sv =====
// Shared types and constants for the linear interpolation pitch resampler.
package lipr_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int PtrWidth    = $clog2(QUEUE_DEPTH);
   localparam int FillWidth   = $clog2(QUEUE_DEPTH + 1);

   localparam int SampleWidth   = 16;
   localparam int ConsumedWidth = 5;
   localparam int MaxPops       = 16;

   localparam logic [31:0] PitchOneBits = 32'h3F80_0000;
   localparam logic [31:0] PitchMinBits = 32'h3C23_D70A;
   localparam logic [31:0] PitchMaxBits = 32'h4180_0000;

   localparam logic [7:0] ExpAllOnes = 8'hFF;
   localparam logic [7:0] ExpShiftBase = 8'd118;

   localparam int WeightWidth = 23;
   localparam int StepWidth   = 38;

   typedef struct packed {
      logic                      action;
      logic signed [SampleWidth-1:0] in_left;
      logic signed [SampleWidth-1:0] in_right;
   } req_payload_type;

   typedef struct packed {
      logic signed [SampleWidth-1:0] out_left;
      logic signed [SampleWidth-1:0] out_right;
      logic [ConsumedWidth-1:0]      consumed;
   } rsp_payload_type;

   localparam logic ActionTick = 1'b0;
   localparam logic ActionPush = 1'b1;

endpackage

// ===== hw/rtl/linear_interp_pitch_resampler_core.sv =====
// Stereo pitch resampler: frame queue, Q32 phase stepping and linear blend.
// A push transaction leaves the core in idle, so it is ready again in the next cycle.
// A tick runs STEP, then POP and LOAD per popped frame (POP alone per underrun pop),
// MULL, MULR and FIN, which waits for a free output; the pop loop goes through the single read port of the frame queue.
// The blend shares one 24 x 17 multiplier between the two channels.
// Synchronous reset clears control, phase and samples; queue contents stay undefined.
module linear_interp_pitch_resampler_core
   import lipr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [31:0]     csr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_STEP  = 3'd1;
   localparam logic [2:0] ST_POP   = 3'd2;
   localparam logic [2:0] ST_LOAD  = 3'd3;
   localparam logic [2:0] ST_MULL  = 3'd4;
   localparam logic [2:0] ST_MULR  = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [31:0] pitch_ff, pitch_in;
   logic [31:0] phase_ff, phase_in;
   logic signed [SampleWidth-1:0] prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic signed [SampleWidth-1:0] cur_l_ff, cur_l_in, cur_r_ff, cur_r_in;
   logic [PtrWidth-1:0]  rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [FillWidth-1:0] fill_ff, fill_in;
   logic [ConsumedWidth-1:0] pops_ff, pops_in, consumed_ff, consumed_in;
   logic signed [40:0] prod_ff, prod_in;
   logic signed [SampleWidth-1:0] left_ff, left_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic [31:0] queue_mem [QUEUE_DEPTH];
   logic [31:0] rd_data_ff;

   logic        push_acc;
   logic [31:0] clamped;
   logic [7:0]  shift_full;
   logic [3:0]  shamt;
   logic [StepWidth-1:0] step;
   logic [StepWidth-1:0] acc;
   logic signed [SampleWidth-1:0] mul_base, mul_target;
   logic signed [23:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [41:0] num;
   logic signed [41:0] num_adj;
   logic signed [SampleWidth-1:0] blend;
   logic        out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign push_acc = req_valid && req_ready && (req_payload.action == ActionPush);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (pitch_ff[30:23] == ExpAllOnes) begin
         clamped = PitchOneBits;
      end else if (pitch_ff[31] || (pitch_ff < PitchMinBits)) begin
         clamped = PitchMinBits;
      end else if (pitch_ff > PitchMaxBits) begin
         clamped = PitchMaxBits;
      end else begin
         clamped = pitch_ff;
      end
      shift_full = clamped[30:23] - ExpShiftBase;
      shamt = shift_full[3:0];
      step = {(StepWidth-24)'(0), 1'b1, clamped[22:0]} << shamt;
      acc = {6'd0, phase_ff} + step;
   end

   always_comb begin
      if (state_ff == ST_MULL) begin
         mul_base = prev_l_ff;
         mul_target = cur_l_ff;
      end else begin
         mul_base = prev_r_ff;
         mul_target = cur_r_ff;
      end
      mul_a = $signed({1'b0, phase_ff[31:9]});
      mul_b = $signed({mul_target[15], mul_target}) - $signed({mul_base[15], mul_base});
      prod_in = mul_a * mul_b;
      num = $signed({{3{prev_r_ff[15]}}, prev_r_ff, 23'd0}) + $signed({prod_ff[40], prod_ff});
      if (state_ff == ST_MULR) begin
         num = $signed({{3{prev_l_ff[15]}}, prev_l_ff, 23'd0}) + $signed({prod_ff[40], prod_ff});
      end
      num_adj = num + (num[41] ? 42'sd8388607 : 42'sd0);
      blend = num_adj[38:23];
   end

   always_comb begin
      state_in = state_ff;
      pitch_in = pitch_ff;
      phase_in = phase_ff;
      prev_l_in = prev_l_ff;
      prev_r_in = prev_r_ff;
      cur_l_in = cur_l_ff;
      cur_r_in = cur_r_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      fill_in = fill_ff;
      pops_in = pops_ff;
      consumed_in = consumed_ff;
      left_in = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;

      if (csr_valid && csr_ready) begin
         pitch_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_payload.action == ActionPush) begin
                  if (fill_ff < FillWidth'(QUEUE_DEPTH)) begin
                     wr_ptr_in = (wr_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
                     fill_in = fill_ff + 1'b1;
                  end
               end else begin
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            phase_in = acc[31:0];
            pops_in = acc[36:32];
            consumed_in = '0;
            state_in = (acc[36:32] == '0) ? ST_MULL : ST_POP;
         end
         ST_POP: begin
            prev_l_in = cur_l_ff;
            prev_r_in = cur_r_ff;
            pops_in = pops_ff - 1'b1;
            if (fill_ff != '0) begin
               state_in = ST_LOAD;
            end else begin
               state_in = (pops_ff == ConsumedWidth'(1)) ? ST_MULL : ST_POP;
            end
         end
         ST_LOAD: begin
            cur_l_in = rd_data_ff[15:0];
            cur_r_in = rd_data_ff[31:16];
            rd_ptr_in = (rd_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
            fill_in = fill_ff - 1'b1;
            consumed_in = consumed_ff + 1'b1;
            state_in = (pops_ff == '0) ? ST_MULL : ST_POP;
         end
         ST_MULL: begin
            state_in = ST_MULR;
         end
         ST_MULR: begin
            left_in = blend;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_in.out_left = left_ff;
               rsp_in.out_right = blend;
               rsp_in.consumed = consumed_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (push_acc && (fill_ff < FillWidth'(QUEUE_DEPTH))) begin
         queue_mem[wr_ptr_ff] <= {req_payload.in_right, req_payload.in_left};
      end
      rd_data_ff <= queue_mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pitch_ff <= PitchOneBits;
         phase_ff <= '0;
         prev_l_ff <= '0;
         prev_r_ff <= '0;
         cur_l_ff <= '0;
         cur_r_ff <= '0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fill_ff <= '0;
         pops_ff <= '0;
         consumed_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pitch_ff <= pitch_in;
         phase_ff <= phase_in;
         prev_l_ff <= prev_l_in;
         prev_r_ff <= prev_r_in;
         cur_l_ff <= cur_l_in;
         cur_r_ff <= cur_r_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff <= fill_in;
         pops_ff <= pops_in;
         consumed_ff <= consumed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      left_ff <= left_in;
      rsp_ff <= rsp_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillWidth'(QUEUE_DEPTH))
      else $error("frame queue fill exceeds its depth");

   a_load_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (fill_ff != '0))
      else $error("frame loaded from an empty queue");

   a_consumed_bound: assert property (@(posedge clock) disable iff (reset)
      consumed_ff <= ConsumedWidth'(MaxPops))
      else $error("more frames consumed than a tick can pop");

   a_fin_to_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) && out_free |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished tick did not present its result");

endmodule

// ===== dv/linear_interp_pitch_resampler_core_test.sv =====
// Self-checking testbench for the linear interpolation pitch resampler core.
module linear_interp_pitch_resampler_core_test
   import lipr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit  = 1_000_000;
   localparam int DrainCycles = 48;
   localparam int RandomItems = 1750;
   localparam int NumSpecial  = 14;
   localparam int ReportLimit = 10;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;
   logic            csr_valid;
   logic            csr_ready;
   logic [31:0]     csr_data;

   int idle_pct;
   int stall_pct;
   int mismatches;
   int unsigned cycle_count = 0;

   logic [31:0]        pitch_bits;
   logic [31:0]        phase_acc;
   logic signed [15:0] prev_l, prev_r, cur_l, cur_r;
   logic [31:0]        frame_store[$];
   rsp_payload_type    pending_outputs[$];
   rsp_payload_type    expected_out;

   linear_interp_pitch_resampler_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] sanitise_pitch(input logic [31:0] b);
      if (b[30:23] == ExpAllOnes) return PitchOneBits;
      if (b[31]) return PitchMinBits;
      if (b < PitchMinBits) return PitchMinBits;
      if (b > PitchMaxBits) return PitchMaxBits;
      return b;
   endfunction

   function automatic logic [37:0] pitch_step(input logic [31:0] b);
      logic [31:0] c;
      int          shift;
      c = sanitise_pitch(b);
      shift = int'(c[30:23]) - 127 + 9;
      return {14'd0, 1'b1, c[22:0]} << shift;
   endfunction

   function automatic logic signed [15:0] blend_sample(input logic signed [15:0] a,
                                                       input logic signed [15:0] b,
                                                       input logic [22:0] w);
      longint al;
      longint bl;
      longint wl;
      longint q;
      al = a;
      bl = b;
      wl = w;
      q = ((64'sd8388608 - wl) * al + wl * bl) / 64'sd8388608;
      return q[15:0];
   endfunction

   function automatic rsp_payload_type resample_tick();
      logic [63:0]     acc;
      logic [31:0]     f;
      int              pops;
      int              used;
      rsp_payload_type r;
      acc = {32'd0, phase_acc} + {26'd0, pitch_step(pitch_bits)};
      pops = int'(acc[63:32]);
      phase_acc = acc[31:0];
      used = 0;
      repeat (pops) begin
         prev_l = cur_l;
         prev_r = cur_r;
         if (frame_store.size() > 0) begin
            f = frame_store.pop_front();
            cur_l = f[15:0];
            cur_r = f[31:16];
            used++;
         end
      end
      r.out_left  = blend_sample(prev_l, cur_l, phase_acc[31:9]);
      r.out_right = blend_sample(prev_r, cur_r, phase_acc[31:9]);
      r.consumed  = used[ConsumedWidth-1:0];
      return r;
   endfunction

   function automatic req_payload_type make_item(input logic action,
                                                 input logic [15:0] l,
                                                 input logic [15:0] r);
      req_payload_type p;
      p.action   = action;
      p.in_left  = l;
      p.in_right = r;
      return p;
   endfunction

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] special_pitch(input int n);
      case (n)
         0: return 32'h7FC0_0000;
         1: return 32'h7F80_0000;
         2: return 32'hFF80_0000;
         3: return 32'hFFFF_FFFF;
         4: return 32'h8000_0000;
         5: return 32'hBF80_0000;
         6: return 32'h0000_0000;
         7: return 32'h0000_0001;
         8: return 32'h3C23_D709;
         9: return PitchMinBits;
         10: return PitchMaxBits;
         11: return 32'h4180_0001;
         12: return PitchOneBits;
         default: return 32'h3F40_0000;
      endcase
   endfunction

   task automatic send_item(input req_payload_type p);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (p.action == ActionPush) begin
         if (frame_store.size() < QUEUE_DEPTH) frame_store.push_back({p.in_right, p.in_left});
      end else begin
         pending_outputs.push_back(resample_tick());
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
   endtask

   task automatic write_pitch(input logic [31:0] bits);
      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= bits;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      pitch_bits = bits;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_sample_extremes();
      idle_pct  = 0;
      stall_pct = 0;
      send_item(make_item(ActionTick, 16'h0000, 16'h0000));
      send_item(make_item(ActionPush, 16'h7FFF, 16'h8000));
      send_item(make_item(ActionPush, 16'h8000, 16'h7FFF));
      send_item(make_item(ActionPush, 16'hFFFF, 16'h0001));
      send_item(make_item(ActionPush, 16'h0001, 16'hFFFF));
      send_item(make_item(ActionTick, 16'hFFFF, 16'hFFFF));
      send_item(make_item(ActionTick, 16'h0000, 16'h0000));
      write_pitch(32'h3FC0_0000);
      send_item(make_item(ActionTick, 16'h0000, 16'h0000));
      send_item(make_item(ActionTick, 16'h0000, 16'h0000));
      send_item(make_item(ActionTick, 16'h0000, 16'h0000));
      send_item(make_item(ActionPush, 16'h8000, 16'h8000));
      send_item(make_item(ActionPush, 16'h7FFF, 16'h7FFF));
      write_pitch(32'h3F40_0000);
      send_item(make_item(ActionTick, 16'h0000, 16'h0000));
      send_item(make_item(ActionTick, 16'h0000, 16'h0000));
      send_item(make_item(ActionTick, 16'h0000, 16'h0000));
      write_pitch(PitchMaxBits);
      send_item(make_item(ActionTick, 16'h0000, 16'h0000));
      send_item(make_item(ActionTick, 16'h0000, 16'h0000));
   endtask

   task automatic test_queue_overflow();
      idle_pct  = 0;
      stall_pct = 0;
      write_pitch(PitchMinBits);
      repeat (QUEUE_DEPTH + 3) send_item(make_item(ActionPush, rand_sample(), rand_sample()));
      write_pitch(PitchMaxBits);
      repeat (5) send_item(make_item(ActionTick, 16'h0000, 16'h0000));
   endtask

   task automatic test_pitch_sweep();
      int          sent;
      int          seg;
      int          seg_len;
      int          push_pct;
      logic [31:0] bits;
      logic        action;
      sent = 0;
      seg  = 0;
      while (sent < RandomItems) begin
         if (seg < NumSpecial) bits = special_pitch(seg);
         else if ($urandom_range(2) == 0) bits = $urandom;
         else bits = {1'b0, 8'($urandom_range(120, 131)), 23'($urandom)};
         write_pitch(bits);
         case (sent * 4 / RandomItems)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 72;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 72;
            end
            default: begin
               idle_pct  = 18;
               stall_pct = 18;
            end
         endcase
         case ($urandom_range(3))
            0: push_pct = 20;
            1: push_pct = 45;
            2: push_pct = 65;
            default: push_pct = 85;
         endcase
         seg_len = $urandom_range(30, 100);
         for (int i = 0; i < seg_len; i++) begin
            if (i == seg_len / 2 && seg % 3 == 1) wait_drained();
            action = ($urandom_range(99) < push_pct) ? ActionPush : ActionTick;
            send_item(make_item(action, rand_sample(), rand_sample()));
         end
         sent += seg_len;
         seg++;
      end
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outputs.size() == 0) begin
            mismatches++;
            if (mismatches <= ReportLimit)
               $display("Unexpected output transaction: left %0d right %0d consumed %0d",
                        rsp_payload.out_left, rsp_payload.out_right, rsp_payload.consumed);
         end else begin
            expected_out = pending_outputs.pop_front();
            if (rsp_payload.out_left !== expected_out.out_left ||
                rsp_payload.out_right !== expected_out.out_right ||
                rsp_payload.consumed !== expected_out.consumed) begin
               mismatches++;
               if (mismatches <= ReportLimit)
                  $display("Output mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                           expected_out.out_left, expected_out.out_right,
                           expected_out.consumed, rsp_payload.out_left,
                           rsp_payload.out_right, rsp_payload.consumed);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_ready   = 1'b0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      idle_pct    = 0;
      stall_pct   = 0;
      mismatches  = 0;
      pitch_bits  = PitchOneBits;
      phase_acc   = '0;
      prev_l      = '0;
      prev_r      = '0;
      cur_l       = '0;
      cur_r       = '0;
      frame_store.delete();
      pending_outputs.delete();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_sample_extremes();
      test_queue_overflow();
      test_pitch_sweep();

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/lipr_pkg.sv
hw/rtl/linear_interp_pitch_resampler_core.sv
dv/linear_interp_pitch_resampler_core_test.sv
